FILE: design/xlb_pkg.sv
package xlb_pkg;

  // Generator geometry
  localparam int LANES        = 16;
  localparam int BUFFER_WORDS = 1024;

  // Derived sizes
  localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int ROUNDS   = (BUFFER_WORDS + LANES - 1) / LANES;
  localparam int ROW_W    = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int WLEFT_W  = $clog2(BUFFER_WORDS + 1);
  localparam int LAST_ROW = (BUFFER_WORDS - 1) / LANES;
  localparam int LAST_COL = (BUFFER_WORDS - 1) % LANES;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Item kinds on the input tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // One buffer row: one word per lane
  typedef logic [LANES-1:0][31:0] row_t;

  // Classified input item
  typedef struct packed {
    logic        draw;
    logic        lane_ok;
    logic [3:0]  lane;
    logic [1:0]  slot;
    logic [31:0] value;
  } cmd_t;

  // Back-end control toward the lane state
  typedef struct packed {
    logic              load;
    logic              step;
    logic [LANE_W-1:0] lane;
    logic [1:0]        slot;
    logic [31:0]       value;
  } lane_ctrl_t;

  // Back-end status for checking
  typedef struct packed {
    logic filling;
    logic issue;
    logic pend;
  } back_stat_t;

endpackage

FILE: design/xlb_front.sv
module xlb_front
  import xlb_pkg::*;
(
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tuser,
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd
);

  // Accept while the queue has room
  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  // Unpack and classify the item
  always_comb begin
    push_cmd.draw    = (s_tuser == MODE_DRAW);
    push_cmd.lane    = s_tdata[3:0];
    push_cmd.slot    = s_tdata[5:4];
    push_cmd.value   = s_tdata[37:6];
    push_cmd.lane_ok = (32'(s_tdata[3:0]) < 32'(LANES));
  end

endmodule

FILE: design/xlb_queue.sv
module xlb_queue
  import xlb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/xlb_lanes.sv
module xlb_lanes
  import xlb_pkg::*;
(
  input  logic       clk,
  input  lane_ctrl_t ctrl,
  output row_t       sums
);

  localparam int SHIFT = 9;
  localparam int ROT   = 11;

  logic [31:0] s0 [LANES];
  logic [31:0] s1 [LANES];
  logic [31:0] s2 [LANES];
  logic [31:0] s3 [LANES];

  // Output word of each lane before its update
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sums[i] = s0[i] + s3[i];
    end
  end

  // Load one seed word or advance every lane
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [31:0] c1;
    logic [31:0] d1;
    logic [31:0] b_next;
    logic [31:0] a_next;
    logic [31:0] c_next;
    logic [31:0] d_next;
    logic        hit;

    always_comb begin
      c1     = s2[g] ^ s0[g];
      d1     = s3[g] ^ s1[g];
      b_next = s1[g] ^ c1;
      a_next = s0[g] ^ d1;
      c_next = c1 ^ (s1[g] << SHIFT);
      d_next = (d1 << ROT) | (d1 >> (32 - ROT));
      hit    = ctrl.load && (ctrl.lane == LANE_W'(g));
    end

    always_ff @(posedge clk) begin
      if (ctrl.step) begin
        s0[g] <= a_next;
        s1[g] <= b_next;
        s2[g] <= c_next;
        s3[g] <= d_next;
      end else if (hit) begin
        case (ctrl.slot)
          2'd0:    s0[g] <= ctrl.value;
          2'd1:    s1[g] <= ctrl.value;
          2'd2:    s2[g] <= ctrl.value;
          default: s3[g] <= ctrl.value;
        endcase
      end
    end
  end

endmodule

FILE: design/xlb_back.sv
module xlb_back
  import xlb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        head,
  output logic        pop,
  output lane_ctrl_t  lane_ctrl,
  input  row_t        sums,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output back_stat_t  stat
);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_FILL = 1'b1;

  logic               state;
  logic               state_next;
  logic [ROW_W-1:0]   fill_row;
  logic [WLEFT_W-1:0] words_left;
  logic [WLEFT_W-1:0] words_left_next;
  logic [ROW_W-1:0]   rd_row;
  logic [LANE_W-1:0]  rd_col;
  logic [LANE_W-1:0]  col_q;
  logic               pend;
  logic               issue;
  logic               fill_done;
  row_t               mem [ROUNDS];
  row_t               rd_data;

  assign fill_done = (fill_row == ROW_W'(LAST_ROW));

  // Decide what the queue head does this cycle
  always_comb begin
    state_next      = state;
    words_left_next = words_left;
    pop             = 1'b0;
    issue           = 1'b0;
    lane_ctrl.load  = 1'b0;
    lane_ctrl.step  = 1'b0;
    lane_ctrl.lane  = LANE_W'(head.lane);
    lane_ctrl.slot  = head.slot;
    lane_ctrl.value = head.value;
    case (state)
      ST_RUN: begin
        if (!q_empty && !head.draw) begin
          lane_ctrl.load  = head.lane_ok;
          pop             = 1'b1;
          words_left_next = '0;
        end else if (!q_empty && head.draw) begin
          if (words_left == '0) begin
            state_next = ST_FILL;
          end else if (!pend && (!m_tvalid || m_tready)) begin
            issue           = 1'b1;
            pop             = 1'b1;
            words_left_next = words_left - 1'b1;
          end
        end
      end
      ST_FILL: begin
        lane_ctrl.step = 1'b1;
        if (fill_done) begin
          state_next      = ST_RUN;
          words_left_next = WLEFT_W'(BUFFER_WORDS);
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      words_left <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      words_left <= words_left_next;
      pend       <= issue;
      if (pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Refill row counter and read position, highest word first
  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      fill_row <= '0;
    end else begin
      fill_row <= fill_row + 1'b1;
    end
    if (state == ST_FILL && fill_done) begin
      rd_row <= ROW_W'(LAST_ROW);
      rd_col <= LANE_W'(LAST_COL);
    end else if (issue) begin
      if (rd_col == '0) begin
        rd_col <= LANE_W'(LANES - 1);
        rd_row <= rd_row - 1'b1;
      end else begin
        rd_col <= rd_col - 1'b1;
      end
    end
  end

  // Word buffer: one lane row written per refill round
  always_ff @(posedge clk) begin
    if (state == ST_FILL) begin
      mem[fill_row] <= sums;
    end
    if (issue) begin
      rd_data <= mem[rd_row];
      col_q   <= rd_col;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (pend) begin
      m_tdata <= rd_data[col_q];
    end
  end

  assign stat.filling = (state == ST_FILL);
  assign stat.issue   = issue;
  assign stat.pend    = pend;

endmodule

FILE: design/xoshiro128_plus_lane_buffer_unit.sv
// Seed load: the lane word is written as the item is popped from the 4-entry queue.
// Draw from a filled buffer: the registered buffer read is followed by the output register
// before m_tvalid; a new draw waits while a read is in flight or the output is stalled.
// Draw on an empty buffer: the back end first enters the refill, then runs ROUNDS (64)
// rounds with all 16 lanes advanced and one buffer row written per round.
// Reset (rst, synchronous, active high) empties queue, buffer count and output;
// lane state and buffer contents are not cleared and must be seeded before a draw.
module xoshiro128_plus_lane_buffer_unit
  import xlb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [3:0] seed_lane, [5:4] seed_slot, [37:6] seed_value
  input  logic        s_tuser,  // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // [31:0] random_word
);

  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  cmd_t       push_cmd;
  cmd_t       head;
  lane_ctrl_t lane_ctrl;
  row_t       sums;
  back_stat_t stat;

  xlb_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  xlb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  xlb_lanes u_lanes (
    .clk  (clk),
    .ctrl (lane_ctrl),
    .sums (sums)
  );

  xlb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .lane_ctrl (lane_ctrl),
    .sums      (sums),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .stat      (stat)
  );

`ifndef ASSERT_OFF
  // A new output item appears only after a buffer read has landed
  a_out_after_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(stat.pend))
    else $error("output valid without a buffer read");

  // No buffer read while the buffer is being refilled
  a_no_read_in_fill: assert property (@(posedge clk) disable iff (rst)
    stat.filling |-> !stat.issue)
    else $error("buffer read during refill");

  // A read in flight blocks the next read
  a_read_spacing: assert property (@(posedge clk) disable iff (rst)
    stat.issue |=> !stat.issue)
    else $error("back-to-back buffer reads");
`endif

endmodule
